### rtl/tcon_pkg.sv
// shared types, constants and codes for the text console
package tcon_pkg;

	localparam int unsigned COLS = 80;
	localparam int unsigned ROWS = 25;
	localparam int unsigned HIST = 200;
	localparam int unsigned TABN = 4;

	localparam int unsigned CELLS = ROWS * COLS;
	localparam int unsigned HCELLS = HIST * COLS;
	localparam int unsigned CAW = $clog2(CELLS);
	localparam int unsigned HAW = $clog2(HCELLS);
	localparam int unsigned RW = 5;
	localparam int unsigned CW = 7;
	localparam int unsigned HW = 8;

	localparam logic [7:0] CH_NL = 8'd10;
	localparam logic [7:0] CH_BS = 8'd8;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_SP = 8'd32;
	localparam logic [7:0] COLOR_RST = 8'd240;

	typedef enum logic [2:0] {
		F_PUT = 3'd0,
		F_SUP = 3'd1,
		F_SDN = 3'd2,
		F_CLR = 3'd3,
		F_RD = 3'd4
	} func_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] char_code;
		logic [7:0] line_count;
		logic [4:0] cell_row;
		logic [6:0] cell_col;
	} in_item_t;

	typedef struct packed {
		logic [7:0] shown_char;
		logic [7:0] shown_color;
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
		logic [7:0] view_offset;
		logic [7:0] history_lines;
		logic viewing_history;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_PRINT,
		S_COPY,
		S_BLANK,
		S_CLEAR,
		S_RDA,
		S_RDB,
		S_RDC,
		S_OUT,
		S_INIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic dec;
		logic print_step;
		logic copy_step;
		logic blank_step;
		logic clear_step;
		logic rd_a;
		logic rd_b;
		logic rd_c;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic go_print;
		logic go_copy;
		logic go_clear;
		logic go_read;
		logic print_more;
		logic sweep_last;
		logic copy_then_print;
	} stat_t;

endpackage

### rtl/text_console_with_scrollback_top.sv
// top level of the text console with scrollback
//  channel | direction | handshake     | payload
//  in      | input     | valid / stall | tcon_pkg::in_item_t
//  out     | output    | valid / stall | tcon_pkg::out_item_t
//  cfg     | input     | valid / ready | text_color byte
// the next item is accepted only once the result of the last one is emitted; a clear
// blanks the screen one screen cell per cycle
// a newline or wrap on the bottom row adds a history copy of the top row, then
// blanking of the new bottom row
// after reset the screen is blanked while the input stalls
// a stalled result holds back only the next result; the next item is still taken
module text_console_with_scrollback_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input tcon_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output tcon_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_data
);

	logic [7:0] color_q;
	tcon_pkg::cmd_t cmd;
	tcon_pkg::stat_t st;
	tcon_pkg::out_item_t res;

	// color register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) color_q <= tcon_pkg::COLOR_RST;
		else if (cfg_valid) color_q <= cfg_data;
	end

	tcon_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.out_busy(out_valid && out_stall), .st(st), .in_stall(in_stall), .cmd(cmd)
	);

	tcon_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .color(color_q),
		.cmd(cmd), .st(st), .res(res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.emit) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.emit) out_data <= res;
	end

	// checks
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid && out_stall)) else $error("result overwritten");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("overlapping commands");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("item taken while busy");

endmodule

### rtl/tcon_ctrl.sv
// controller state machine of the text console
module tcon_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic out_busy,
	input tcon_pkg::stat_t st,
	output logic in_stall,
	output tcon_pkg::cmd_t cmd
);

	tcon_pkg::state_t state_q, state_d;

	// state register, screen blanking sweep first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tcon_pkg::S_INIT;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			tcon_pkg::S_INIT: begin
				cmd.clear_step = 1'b1;
				if (st.sweep_last) state_d = tcon_pkg::S_IDLE;
			end
			tcon_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = tcon_pkg::S_DEC;
				end
			end
			tcon_pkg::S_DEC: begin
				cmd.dec = 1'b1;
				priority if (st.go_copy) state_d = tcon_pkg::S_COPY;
				else if (st.go_print) state_d = tcon_pkg::S_PRINT;
				else if (st.go_clear) state_d = tcon_pkg::S_CLEAR;
				else if (st.go_read) state_d = tcon_pkg::S_RDA;
				else state_d = tcon_pkg::S_OUT;
			end
			tcon_pkg::S_PRINT: begin
				cmd.print_step = 1'b1;
				priority if (st.go_copy) state_d = tcon_pkg::S_COPY;
				else if (st.print_more) state_d = tcon_pkg::S_PRINT;
				else state_d = tcon_pkg::S_OUT;
			end
			tcon_pkg::S_COPY: begin
				cmd.copy_step = 1'b1;
				if (st.sweep_last) state_d = tcon_pkg::S_BLANK;
			end
			tcon_pkg::S_BLANK: begin
				cmd.blank_step = 1'b1;
				if (st.sweep_last)
					state_d = st.copy_then_print ? tcon_pkg::S_PRINT : tcon_pkg::S_OUT;
			end
			tcon_pkg::S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (st.sweep_last) state_d = tcon_pkg::S_OUT;
			end
			tcon_pkg::S_RDA: begin
				cmd.rd_a = 1'b1;
				state_d = tcon_pkg::S_RDB;
			end
			tcon_pkg::S_RDB: begin
				cmd.rd_b = 1'b1;
				state_d = tcon_pkg::S_RDC;
			end
			tcon_pkg::S_RDC: begin
				cmd.rd_c = 1'b1;
				state_d = tcon_pkg::S_OUT;
			end
			tcon_pkg::S_OUT: begin
				if (!out_busy) begin
					cmd.emit = 1'b1;
					state_d = tcon_pkg::S_IDLE;
				end
			end
			default: state_d = tcon_pkg::S_IDLE;
		endcase
	end

endmodule

### rtl/tcon_dp.sv
// datapath of the text console: registers, screen and history memories
module tcon_dp (
	input logic clk,
	input logic arst_n,
	input tcon_pkg::in_item_t in_item,
	input logic [7:0] color,
	input tcon_pkg::cmd_t cmd,
	output tcon_pkg::stat_t st,
	output tcon_pkg::out_item_t res
);

	logic [15:0] scr_mem [tcon_pkg::CELLS];
	logic [7:0] hist_mem [tcon_pkg::HCELLS];

	tcon_pkg::in_item_t item_q;
	logic [tcon_pkg::RW-1:0] top_q, row_q;
	logic [tcon_pkg::CW-1:0] col_q;
	logic [tcon_pkg::HW-1:0] head_q, fill_q, off_q;
	logic view_q;
	logic [3:0] left_q;
	logic [tcon_pkg::CW-1:0] sweep_q;
	logic [tcon_pkg::RW-1:0] srow_q;
	logic [tcon_pkg::HW-1:0] slot_q;
	logic resume_q;
	logic [7:0] sh_ch_q, sh_co_q;
	logic [15:0] scr_rd_q;
	logic [7:0] hist_rd_q;
	logic use_hist_q, in_range_q;
	logic [tcon_pkg::RW-1:0] lrow_q;

	// physical screen row of a logical row
	function automatic logic [tcon_pkg::RW-1:0] phys(input logic [tcon_pkg::RW-1:0] t,
			input logic [tcon_pkg::RW-1:0] r);
		logic [tcon_pkg::RW:0] s;
		s = {1'b0, t} + {1'b0, r};
		if (s >= (tcon_pkg::RW+1)'(tcon_pkg::ROWS)) s = s - (tcon_pkg::RW+1)'(tcon_pkg::ROWS);
		return s[tcon_pkg::RW-1:0];
	endfunction

	function automatic logic [tcon_pkg::CAW-1:0] caddr(input logic [tcon_pkg::RW-1:0] p,
			input logic [tcon_pkg::CW-1:0] c);
		return tcon_pkg::CAW'(p) * tcon_pkg::CAW'(tcon_pkg::COLS) + tcon_pkg::CAW'(c);
	endfunction

	logic bottom, wrap_pend, is_put, is_tab, is_nl;
	logic [tcon_pkg::HW-1:0] push_slot;
	logic [tcon_pkg::HW:0] slot_sum;
	logic [tcon_pkg::RW-1:0] top_next;

	assign bottom = (row_q == tcon_pkg::RW'(tcon_pkg::ROWS - 1));
	assign wrap_pend = (col_q >= tcon_pkg::CW'(tcon_pkg::COLS));
	assign is_put = (item_q.func == tcon_pkg::F_PUT);
	assign is_tab = (item_q.char_code == tcon_pkg::CH_TAB);
	assign is_nl = (item_q.char_code == tcon_pkg::CH_NL);
	assign slot_sum = {1'b0, head_q} + {1'b0, fill_q};
	assign push_slot = (fill_q < tcon_pkg::HW'(tcon_pkg::HIST))
		? ((slot_sum >= (tcon_pkg::HW+1)'(tcon_pkg::HIST))
			? tcon_pkg::HW'(slot_sum - (tcon_pkg::HW+1)'(tcon_pkg::HIST))
			: slot_sum[tcon_pkg::HW-1:0])
		: head_q;
	assign top_next = (top_q == tcon_pkg::RW'(tcon_pkg::ROWS - 1)) ? '0 : top_q + 1'b1;

	// status to the controller
	always_comb begin
		st = '0;
		st.go_clear = (item_q.func == tcon_pkg::F_CLR);
		st.go_read = (item_q.func == tcon_pkg::F_RD);
		st.go_print = is_put && (item_q.char_code != tcon_pkg::CH_NL)
			&& (item_q.char_code != tcon_pkg::CH_BS);
		if (cmd.dec) st.go_copy = is_put && bottom && (is_nl || (st.go_print && wrap_pend));
		else st.go_copy = wrap_pend && bottom;
		st.print_more = (left_q > 4'd1);
		st.sweep_last = (sweep_q == tcon_pkg::CW'(tcon_pkg::COLS - 1))
			&& (!cmd.clear_step || srow_q == tcon_pkg::RW'(tcon_pkg::ROWS - 1));
		st.copy_then_print = resume_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0; row_q <= '0; col_q <= '0;
			head_q <= '0; fill_q <= '0; off_q <= '0; view_q <= 1'b0;
			left_q <= '0; sweep_q <= '0; srow_q <= '0; resume_q <= 1'b0;
			slot_q <= '0;
		end else begin
			if (cmd.dec) begin
				sweep_q <= '0; srow_q <= '0;
				left_q <= is_tab ? 4'(tcon_pkg::TABN) : 4'd1;
				resume_q <= st.go_print;
				unique case (item_q.func)
					tcon_pkg::F_PUT: begin
						off_q <= '0; view_q <= 1'b0;
						if (is_nl) begin
							col_q <= '0;
							if (!bottom) row_q <= row_q + 1'b1;
						end else if (item_q.char_code == tcon_pkg::CH_BS) begin
							if (wrap_pend) col_q <= tcon_pkg::CW'(tcon_pkg::COLS - 1);
							else if (col_q != '0) col_q <= col_q - 1'b1;
							else if (row_q != '0) begin
								row_q <= row_q - 1'b1;
								col_q <= tcon_pkg::CW'(tcon_pkg::COLS - 1);
							end
						end
					end
					tcon_pkg::F_SUP: begin
						view_q <= 1'b1;
						if (item_q.line_count > fill_q - off_q) off_q <= fill_q;
						else off_q <= off_q + item_q.line_count;
					end
					tcon_pkg::F_SDN: begin
						if (item_q.line_count >= off_q) begin
							off_q <= '0; view_q <= 1'b0;
						end else off_q <= off_q - item_q.line_count;
					end
					tcon_pkg::F_CLR: begin
						row_q <= '0; col_q <= '0; head_q <= '0; fill_q <= '0;
						off_q <= '0; view_q <= 1'b0; top_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.dec && st.go_copy) slot_q <= push_slot;
			// one cell per step; a wrap on the bottom row detours through the copy
			if (cmd.print_step) begin
				if (!st.go_copy) begin
					col_q <= (wrap_pend ? '0 : col_q) + 1'b1;
					left_q <= left_q - 1'b1;
					if (wrap_pend && !bottom) row_q <= row_q + 1'b1;
				end else begin
					slot_q <= push_slot;
					sweep_q <= '0;
					resume_q <= 1'b1;
				end
			end
			if (cmd.copy_step) begin
				if (st.sweep_last) begin
					sweep_q <= '0;
					if (fill_q < tcon_pkg::HW'(tcon_pkg::HIST)) fill_q <= fill_q + 1'b1;
					else head_q <= (head_q == tcon_pkg::HW'(tcon_pkg::HIST - 1)) ? '0
						: head_q + 1'b1;
					top_q <= top_next;
					if (resume_q) col_q <= '0;
				end else sweep_q <= sweep_q + 1'b1;
			end
			if (cmd.blank_step) sweep_q <= st.sweep_last ? '0 : sweep_q + 1'b1;
			if (cmd.clear_step) begin
				if (sweep_q == tcon_pkg::CW'(tcon_pkg::COLS - 1)) begin
					sweep_q <= '0; srow_q <= srow_q + 1'b1;
				end else sweep_q <= sweep_q + 1'b1;
			end
		end
	end

	// screen memory write port, one cell per cycle
	logic scr_we;
	logic [tcon_pkg::CAW-1:0] scr_wa;
	logic [15:0] scr_wd;
	logic [tcon_pkg::CW-1:0] bs_col;
	logic [tcon_pkg::RW-1:0] bs_row;

	always_comb begin
		bs_row = row_q; bs_col = col_q;
		if (wrap_pend) bs_col = tcon_pkg::CW'(tcon_pkg::COLS - 1);
		else if (col_q != '0) bs_col = col_q - 1'b1;
		else if (row_q != '0) begin
			bs_row = row_q - 1'b1; bs_col = tcon_pkg::CW'(tcon_pkg::COLS - 1);
		end
		scr_we = 1'b0; scr_wa = '0; scr_wd = {color, tcon_pkg::CH_SP};
		if (cmd.dec && is_put && item_q.char_code == tcon_pkg::CH_BS) begin
			scr_we = 1'b1; scr_wa = caddr(phys(top_q, bs_row), bs_col);
		end else if (cmd.print_step && !st.go_copy) begin
			scr_we = 1'b1;
			scr_wa = caddr(phys(top_q, wrap_pend ? (bottom ? row_q : row_q + 1'b1) : row_q),
				wrap_pend ? '0 : col_q);
			scr_wd = {color, is_tab ? tcon_pkg::CH_SP : item_q.char_code};
		end else if (cmd.blank_step) begin
			scr_we = 1'b1;
			scr_wa = caddr(phys(top_q, tcon_pkg::RW'(tcon_pkg::ROWS - 1)), sweep_q);
		end else if (cmd.clear_step) begin
			scr_we = 1'b1; scr_wa = caddr(srow_q, sweep_q);
		end
	end

	// read address: copy sweep or displayed cell
	logic [tcon_pkg::CAW-1:0] scr_ra;
	logic [tcon_pkg::HAW-1:0] hist_ra;
	logic [tcon_pkg::HW:0] line_w;
	logic [tcon_pkg::HW+1:0] hsum;
	logic [tcon_pkg::HW-1:0] hline;

	assign line_w = {1'b0, fill_q - off_q} + (tcon_pkg::HW+1)'(item_q.cell_row);
	always_comb begin
		hsum = {2'b0, head_q} + {1'b0, line_w};
		if (hsum >= (tcon_pkg::HW+2)'(tcon_pkg::HIST))
			hsum = hsum - (tcon_pkg::HW+2)'(tcon_pkg::HIST);
		hline = hsum[tcon_pkg::HW-1:0];
	end

	// copy pipeline: screen read, then history write in the cycle after
	logic cp_we_s1;
	logic [tcon_pkg::HAW-1:0] cp_wa_s1;
	always_comb begin
		scr_ra = caddr(phys(top_q, item_q.cell_row), item_q.cell_col);
		if (cmd.copy_step) scr_ra = caddr(top_q, sweep_q);
		else if (cmd.rd_b && use_hist_q == 1'b0)
			scr_ra = caddr(phys(top_q, lrow_q), item_q.cell_col);
	end

	always_ff @(posedge clk) begin
		if (scr_we) scr_mem[scr_wa] <= scr_wd;
		scr_rd_q <= scr_mem[scr_ra];
		if (cp_we_s1) hist_mem[cp_wa_s1] <= scr_rd_q[7:0];
		hist_rd_q <= hist_mem[hist_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cp_we_s1 <= 1'b0;
		else cp_we_s1 <= cmd.copy_step;
	end
	always_ff @(posedge clk) begin
		cp_wa_s1 <= tcon_pkg::HAW'(slot_q) * tcon_pkg::HAW'(tcon_pkg::COLS)
			+ tcon_pkg::HAW'(sweep_q);
	end
	assign hist_ra = tcon_pkg::HAW'(hline) * tcon_pkg::HAW'(tcon_pkg::COLS)
		+ tcon_pkg::HAW'(item_q.cell_col);

	// read_cell sequence
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
		if (cmd.rd_a) begin
			in_range_q <= (item_q.cell_row < tcon_pkg::RW'(tcon_pkg::ROWS))
				&& (item_q.cell_col < tcon_pkg::CW'(tcon_pkg::COLS));
			use_hist_q <= view_q && (line_w < (tcon_pkg::HW+1)'(fill_q));
			lrow_q <= view_q ? tcon_pkg::RW'(line_w - (tcon_pkg::HW+1)'(fill_q))
				: item_q.cell_row;
		end
		if (cmd.rd_b) sh_co_q <= scr_rd_q[15:8];
		if (cmd.rd_c) sh_ch_q <= use_hist_q ? hist_rd_q : scr_rd_q[7:0];
	end

	// result fields
	always_comb begin
		res = '0;
		if (item_q.func == tcon_pkg::F_RD && in_range_q) begin
			res.shown_char = sh_ch_q;
			res.shown_color = sh_co_q;
		end
		res.cursor_row = row_q;
		res.cursor_col = col_q;
		res.view_offset = off_q;
		res.history_lines = fill_q;
		res.viewing_history = view_q;
	end

endmodule
